// File: design/patd_pkg.sv
// Shared types and constants for the phase-angle triac dimmer.
// No dependencies; imported by every module of the block.
package patd_pkg;

  localparam int unsigned CntW    = 10;
  localparam int unsigned LevelW  = 8;
  localparam int unsigned ChanW   = 2;
  localparam int unsigned MaskW   = 4;
  localparam int unsigned ActW    = 2;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CntW-1:0]   OffReset   = 10'd550;
  localparam logic [CntW-1:0]   TopReset   = 10'd625;
  localparam logic [CntW-1:0]   SyncReset  = 10'd620;
  localparam logic [CntW-1:0]   DelayBase  = 10'd512;
  localparam logic [LevelW-1:0] FullLevel  = 8'd255;
  localparam logic [LevelW-1:0] OffLevel   = 8'd0;

  typedef enum logic [ActW-1:0] {
    ActTick      = 2'd0,
    ActZeroCross = 2'd1,
    ActSetLevel  = 2'd2
  } act_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgOffPoint  = 2'd0,
    CfgPeriodTop = 2'd1,
    CfgSyncLoad  = 2'd2
  } cfg_reg_e;

  // per-request control from the phase counter to the channels
  typedef struct packed {
    logic            latch;
    logic            compare;
    logic [CntW-1:0] count;
  } patd_ctrl_t;

  // per-channel status back to the gate register
  typedef struct packed {
    logic hit;
    logic full;
  } patd_chan_t;

endpackage

// File: design/patd_phase.sv
// Phase counter and configuration registers of the dimmer.
// Depends on patd_pkg.
module patd_phase (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [patd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [patd_pkg::CntW-1:0]     cfg_wdata_i,
  input  logic                          step_i,
  input  logic [patd_pkg::ActW-1:0]     action_i,
  output patd_pkg::patd_ctrl_t          ctrl_o
);
  import patd_pkg::*;

  logic [CntW-1:0] off_point_q, period_top_q, sync_load_q;
  logic [CntW-1:0] count_q, count_d, tick_count;
  logic            is_tick;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_point_q  <= OffReset;
      period_top_q <= TopReset;
      sync_load_q  <= SyncReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgOffPoint:  off_point_q  <= cfg_wdata_i;
        CfgPeriodTop: period_top_q <= cfg_wdata_i;
        CfgSyncLoad:  sync_load_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    tick_count = (count_q >= period_top_q) ? '0 : count_q + 10'd1;
    is_tick    = 1'b0;
    count_d    = count_q;
    if (step_i) begin
      case (action_i)
        ActTick: begin
          is_tick = 1'b1;
          count_d = tick_count;
        end
        ActZeroCross: count_d = sync_load_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign ctrl_o.latch   = is_tick && (count_d == off_point_q);
  assign ctrl_o.compare = is_tick && (count_d != off_point_q);
  assign ctrl_o.count   = count_d;

endmodule

// File: design/patd_channel.sv
// One dimmer channel: pending and active levels and the turn-on compare.
// Depends on patd_pkg.
module patd_channel (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  patd_pkg::patd_ctrl_t         ctrl_i,
  input  logic                         set_i,
  input  logic [patd_pkg::LevelW-1:0]  brightness_i,
  output patd_pkg::patd_chan_t         stat_o
);
  import patd_pkg::*;

  logic [CntW-1:0] pend_delay_q, act_delay_q, level_delay;
  logic            pend_lit_q, pend_full_q, act_lit_q;

  assign level_delay = (brightness_i == OffLevel) ? OffReset
                     : DelayBase - {1'b0, brightness_i, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_delay_q <= OffReset;
      pend_lit_q   <= 1'b0;
      pend_full_q  <= 1'b0;
    end else if (set_i) begin
      pend_delay_q <= level_delay;
      pend_lit_q   <= (brightness_i != OffLevel);
      pend_full_q  <= (brightness_i == FullLevel);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_delay_q <= OffReset;
      act_lit_q   <= 1'b0;
    end else if (ctrl_i.latch) begin
      act_delay_q <= pend_delay_q;
      act_lit_q   <= pend_lit_q;
    end
  end

  assign stat_o.hit  = ctrl_i.compare && act_lit_q && (act_delay_q == ctrl_i.count);
  assign stat_o.full = pend_full_q;

endmodule

// File: design/phase_angle_triac_dimmer.sv
// Leading-edge phase-angle triac dimmer, top level. A request passes
// through the input register, then the result register. Throughput: one
// request per cycle, sustained while out_ready_i does not stall the output.
// Asynchronous active-low reset clears counter, gates and levels and loads
// the configuration defaults.
// Depends on patd_pkg, patd_phase and patd_channel.
module phase_angle_triac_dimmer #(
  parameter int unsigned CHANNELS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [patd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [patd_pkg::CntW-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [patd_pkg::ActW-1:0]     action_i,
  input  logic [patd_pkg::ChanW-1:0]    channel_i,
  input  logic [patd_pkg::LevelW-1:0]   brightness_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [patd_pkg::MaskW-1:0]    gate_mask_o,
  output logic [patd_pkg::CntW-1:0]     phase_count_o
);
  import patd_pkg::*;

  logic              s1_valid_q;
  logic [ActW-1:0]   s1_action_q;
  logic [ChanW-1:0]  s1_channel_q;
  logic [LevelW-1:0] s1_bright_q;
  logic              step, in_acc;

  logic                out_valid_q;
  logic [MaskW-1:0]    gate_mask_q, gate_mask_d;
  logic [CntW-1:0]     count_out_q;

  logic [CHANNELS-1:0] gate_q, gate_d, hit_mask, full_mask, set_mask;
  patd_ctrl_t          ctrl;
  patd_chan_t          stat [CHANNELS];

  assign step       = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || step;
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (step) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_action_q  <= action_i;
      s1_channel_q <= channel_i;
      s1_bright_q  <= brightness_i;
    end
  end

  patd_phase u_phase (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .step_i   (step),
    .action_i (s1_action_q),
    .ctrl_o   (ctrl)
  );

  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    assign set_mask[c] = step && (s1_action_q == ActSetLevel)
                         && (int'(s1_channel_q) == c);

    patd_channel u_chan (
      .clk_i,
      .rst_ni,
      .ctrl_i       (ctrl),
      .set_i        (set_mask[c]),
      .brightness_i (s1_bright_q),
      .stat_o       (stat[c])
    );

    assign hit_mask[c]  = stat[c].hit;
    assign full_mask[c] = stat[c].full;
  end

  always_comb begin
    gate_d = gate_q;
    if (ctrl.latch) begin
      gate_d = full_mask;
    end else if (ctrl.compare) begin
      gate_d = gate_q | hit_mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_q <= '0;
    end else begin
      gate_q <= gate_d;
    end
  end

  for (genvar i = 0; i < MaskW; i++) begin : g_mask
    if (i < CHANNELS) begin : g_used
      assign gate_mask_d[i] = gate_d[i];
    end else begin : g_unused
      assign gate_mask_d[i] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      gate_mask_q <= gate_mask_d;
      count_out_q <= ctrl.count;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign gate_mask_o   = gate_mask_q;
  assign phase_count_o = count_out_q;

endmodule

// File: design/patd_checker.sv
// Port-level checks for the phase-angle triac dimmer, bound to the top level.
// Depends on patd_pkg and phase_angle_triac_dimmer.
module patd_checker #(
  parameter int unsigned CHANNELS = 4
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [patd_pkg::MaskW-1:0]    gate_mask_o,
  input logic [patd_pkg::CntW-1:0]     phase_count_o
);
  import patd_pkg::*;

  localparam logic [MaskW-1:0] UsedMask =
    (CHANNELS >= MaskW) ? {MaskW{1'b1}} : MaskW'((1 << CHANNELS) - 1);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(gate_mask_o) && $stable(phase_count_o))
    else $error("result changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  a_unused_gates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((gate_mask_o & ~UsedMask) == '0))
    else $error("gate driven on a missing channel");

endmodule

bind phase_angle_triac_dimmer patd_checker #(.CHANNELS(CHANNELS)) u_patd_checker (.*);
